FILE: src/lrmt_pkg.sv
package lrmt_pkg;

	localparam int LEAVES  = 1024;
	localparam int LEAF_W  = $clog2(LEAVES);
	localparam int NODE_AW = LEAF_W + 1;
	localparam int NODES   = 2 * LEAVES;
	localparam int LVL_W   = $clog2(LEAF_W + 1);
	localparam int SIZE_W  = 11;
	localparam int AMT_W   = 48;
	localparam int VAL_W   = 64;

	localparam logic [VAL_W-1:0] EMPTY_MIN = 64'd10000000000000000;
	localparam logic [VAL_W-1:0] MAX_POS   = {1'b0, {(VAL_W-1){1'b1}}};

	typedef enum logic [1:0] {
		FN_LOAD  = 2'd0,
		FN_ADD   = 2'd1,
		FN_QUERY = 2'd2
	} func_t;

	typedef struct packed {
		logic [VAL_W-1:0] min_val;
		logic [VAL_W-1:0] pend;
	} node_t;

	typedef struct packed {
		func_t             op;
		logic [LEAF_W-1:0] l;
		logic [LEAF_W-1:0] r;
		logic [VAL_W-1:0]  x;
	} cmd_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [VAL_W-1:0] minimum;
	} stat_t;

	function automatic logic [VAL_W-1:0] smin(input logic [VAL_W-1:0] a,
			input logic [VAL_W-1:0] b);
		return ($signed(a) < $signed(b)) ? a : b;
	endfunction

	// low leaf bits spanned by a node at the given depth (root is depth 0)
	function automatic logic [LEAF_W-1:0] span_mask(input logic [LVL_W-1:0] lvl);
		logic [LEAF_W:0] bit_hi;
		bit_hi = (LEAF_W+1)'(1) << (LVL_W'(LEAF_W) - lvl);
		return LEAF_W'(bit_hi - 1'b1);
	endfunction

	// heap index of the ancestor of a leaf at the given depth
	function automatic logic [NODE_AW-1:0] node_index(input logic [LVL_W-1:0] lvl,
			input logic [LEAF_W-1:0] leaf);
		logic [NODE_AW-1:0] full;
		full = {1'b1, leaf};
		return full >> (LVL_W'(LEAF_W) - lvl);
	endfunction

endpackage

FILE: src/lazy_range_add_range_min_tree.sv
// Lazy segment tree over LEAVES signed 64-bit values: load a leaf, add to an
// inclusive index range, or query the minimum of an inclusive index range.
// Input channel: an item is taken when start is high and busy is low; func,
// left_index, right_index and amount are sampled at that edge.
// Result channel: a query gives one result on minimum while result_valid is
// high for one cycle; loads and adds give none. The receiver cannot stall.
// Config channel: cfg_data (used_size) is written when cfg_valid is high;
// cfg_ready is always high.
// After reset the node memory is swept to zero, one node per cycle, which
// keeps busy high until all 2048 nodes are written; config writes are taken meanwhile.
// An empty-range query returns in the next cycle. Otherwise the walk visits
// up to two nodes per level over ten levels through one memory read port:
// a pushed node reads itself and both children and writes all three, a
// recomputed node reads both children and writes itself. A full-range add
// or query touches only the root; ignored items leave busy low.
module lazy_range_add_range_min_tree import lrmt_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              func,
	input  logic [LEAF_W-1:0]       left_index,
	input  logic [LEAF_W-1:0]       right_index,
	input  logic signed [AMT_W-1:0] amount,
	output logic                    result_valid,
	output logic signed [VAL_W-1:0] minimum,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [SIZE_W-1:0]       cfg_data
);

	logic [SIZE_W-1:0] used_size_q;
	logic              empty_q;

	logic [SIZE_W-1:0]  size_eff;
	logic [SIZE_W-1:0]  last_idx;
	logic [LEAF_W-1:0]  r_eff;
	logic               empty;
	logic               load_ok;
	logic               want;
	logic               go;
	cmd_t               cmd;
	stat_t              stat;
	logic               wr_en;
	logic [NODE_AW-1:0] wr_addr;
	node_t              wr_data;
	logic [NODE_AW-1:0] rd_addr;
	node_t              rd_data;

	always_comb begin
		size_eff = (used_size_q > SIZE_W'(LEAVES)) ? SIZE_W'(LEAVES) : used_size_q;
		last_idx = size_eff - 1'b1;
		if (size_eff != '0 && SIZE_W'(right_index) > last_idx) begin
			r_eff = last_idx[LEAF_W-1:0];
		end else begin
			r_eff = right_index;
		end
		empty   = (size_eff == '0) || (left_index > r_eff);
		load_ok = SIZE_W'(left_index) < size_eff;
		unique case (func)
			FN_LOAD:  want = load_ok;
			FN_ADD:   want = !empty;
			FN_QUERY: want = !empty;
			default:  want = 1'b0;
		endcase
		cmd.op = func_t'(func);
		cmd.l  = left_index;
		cmd.r  = r_eff;
		cmd.x  = {{(VAL_W-AMT_W){amount[AMT_W-1]}}, amount};
	end

	assign go = start && !busy && want;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_size_q <= SIZE_W'(LEAVES);
			empty_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				used_size_q <= cfg_data;
			end
			empty_q <= start && !busy && (func == FN_QUERY) && empty;
		end
	end

	lrmt_node_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	lrmt_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go),
		.cmd     (cmd),
		.stat    (stat),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign busy         = stat.busy;
	assign cfg_ready    = 1'b1;
	assign result_valid = empty_q || stat.done;
	assign minimum      = empty_q ? EMPTY_MIN : stat.minimum;

endmodule

FILE: src/lrmt_node_ram.sv
module lrmt_node_ram import lrmt_pkg::*; (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [NODE_AW-1:0] wr_addr,
	input  node_t              wr_data,
	input  logic [NODE_AW-1:0] rd_addr,
	output node_t              rd_data
);

	node_t mem [NODES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

FILE: src/lrmt_seq.sv
module lrmt_seq import lrmt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  cmd_t               cmd,
	output stat_t              stat,
	output logic               wr_en,
	output logic [NODE_AW-1:0] wr_addr,
	output node_t              wr_data,
	output logic [NODE_AW-1:0] rd_addr,
	input  node_t              rd_data
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ROOT,
		S_DOWN,
		S_LEAF,
		S_UP,
		S_DONE
	} state_t;

	state_t             state_q;
	logic [NODE_AW-1:0] clr_q;
	logic [LVL_W-1:0]   lvl_q;
	logic               side_q;
	logic [1:0]         ph_q;

	cmd_t             cmd_q;
	logic [VAL_W-1:0] p_q;
	logic [VAL_W-1:0] px_q;
	logic [VAL_W-1:0] c0_q;
	logic [VAL_W-1:0] acc_q;

	logic [LEAF_W-1:0]  sel_leaf;
	logic [LEAF_W-1:0]  mask;
	logic [LEAF_W-1:0]  half;
	logic [LEAF_W-1:0]  node_lo;
	logic [LEAF_W-1:0]  node_hi;
	logic [LEAF_W-1:0]  mid;
	logic [LEAF_W-1:0]  c1_lo;
	logic               covered;
	logic               cov0;
	logic               cov1;
	logic               cov_cur;
	logic               same;
	logic               active;
	logic               root_cov;
	logic [NODE_AW-1:0] node;
	logic [NODE_AW-1:0] child0;
	logic [NODE_AW-1:0] child1;
	logic [VAL_W-1:0]   add_val;
	node_t              ch_new;

	// slot = (depth, side): side 0 follows the path to l, side 1 the path to r
	always_comb begin
		sel_leaf = side_q ? cmd_q.r : cmd_q.l;
		mask     = span_mask(lvl_q);
		half     = mask >> 1;
		node_lo  = sel_leaf & ~mask;
		node_hi  = sel_leaf | mask;
		mid      = node_lo | half;
		c1_lo    = node_lo | (mask ^ half);
		covered  = (node_lo >= cmd_q.l) && (node_hi <= cmd_q.r);
		cov0     = (node_lo >= cmd_q.l) && (mid <= cmd_q.r);
		cov1     = (c1_lo >= cmd_q.l) && (node_hi <= cmd_q.r);
		same     = (cmd_q.l & ~mask) == (cmd_q.r & ~mask);
		if (cmd_q.op == FN_LOAD) begin
			active = !side_q;
		end else begin
			active = !covered && !(side_q && same);
		end
		node     = node_index(lvl_q, sel_leaf);
		child0   = {node[NODE_AW-2:0], 1'b0};
		child1   = {node[NODE_AW-2:0], 1'b1};
		cov_cur  = (ph_q == 2'd2) ? cov0 : cov1;
		add_val  = (cmd_q.op == FN_ADD && cov_cur) ? px_q : p_q;
		ch_new.min_val = rd_data.min_val + add_val;
		ch_new.pend    = rd_data.pend + add_val;
		root_cov = (cmd.l == '0) && (cmd.r == '1) && (cmd.op != FN_LOAD);
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = node;
		wr_data = '0;
		rd_addr = node;
		unique case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
			end
			S_ROOT: begin
				rd_addr = NODE_AW'(1);
				wr_addr = NODE_AW'(1);
				if (ph_q == 2'd1 && cmd_q.op == FN_ADD) begin
					wr_en           = 1'b1;
					wr_data.min_val = rd_data.min_val + cmd_q.x;
					wr_data.pend    = rd_data.pend + cmd_q.x;
				end
			end
			S_DOWN: begin
				case (ph_q)
					2'd0: rd_addr = node;
					2'd1: begin
						rd_addr         = child0;
						wr_en           = 1'b1;
						wr_addr         = node;
						wr_data.min_val = rd_data.min_val;
					end
					2'd2: begin
						rd_addr = child1;
						wr_en   = 1'b1;
						wr_addr = child0;
						wr_data = ch_new;
					end
					default: begin
						wr_en   = 1'b1;
						wr_addr = child1;
						wr_data = ch_new;
					end
				endcase
			end
			S_LEAF: begin
				wr_en           = 1'b1;
				wr_addr         = {1'b1, cmd_q.l};
				wr_data.min_val = cmd_q.x;
			end
			S_UP: begin
				case (ph_q)
					2'd0: rd_addr = child0;
					2'd1: rd_addr = child1;
					default: begin
						wr_en           = 1'b1;
						wr_addr         = node;
						wr_data.min_val = smin(c0_q, rd_data.min_val);
					end
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			lvl_q   <= '0;
			side_q  <= 1'b0;
			ph_q    <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					lvl_q  <= '0;
					side_q <= 1'b0;
					ph_q   <= '0;
					if (go) begin
						state_q <= root_cov ? S_ROOT : S_DOWN;
					end
				end
				S_ROOT: begin
					ph_q <= ph_q + 1'b1;
					if (ph_q == 2'd1) begin
						state_q <= S_DONE;
					end
				end
				S_DOWN: begin
					if ((ph_q == 2'd0 && !active) || ph_q == 2'd3) begin
						ph_q <= '0;
						if (!side_q) begin
							side_q <= 1'b1;
						end else if (lvl_q == LVL_W'(LEAF_W - 1)) begin
							side_q <= 1'b0;
							unique case (cmd_q.op)
								FN_QUERY: state_q <= S_DONE;
								FN_LOAD:  state_q <= S_LEAF;
								default:  state_q <= S_UP;
							endcase
						end else begin
							side_q <= 1'b0;
							lvl_q  <= lvl_q + 1'b1;
						end
					end else begin
						ph_q <= ph_q + 1'b1;
					end
				end
				S_LEAF: begin
					state_q <= S_UP;
				end
				S_UP: begin
					if ((ph_q == 2'd0 && !active) || ph_q == 2'd2) begin
						ph_q <= '0;
						if (!side_q) begin
							side_q <= 1'b1;
						end else if (lvl_q == '0) begin
							state_q <= S_DONE;
						end else begin
							side_q <= 1'b0;
							lvl_q  <= lvl_q - 1'b1;
						end
					end else begin
						ph_q <= ph_q + 1'b1;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && go) begin
			cmd_q <= cmd;
			acc_q <= MAX_POS;
		end
		if (state_q == S_ROOT && ph_q == 2'd1) begin
			acc_q <= rd_data.min_val;
		end
		if (state_q == S_DOWN && ph_q == 2'd1) begin
			p_q  <= rd_data.pend;
			px_q <= rd_data.pend + cmd_q.x;
		end
		if (state_q == S_DOWN && (ph_q == 2'd2 || ph_q == 2'd3)
				&& cmd_q.op == FN_QUERY && cov_cur) begin
			acc_q <= smin(acc_q, ch_new.min_val);
		end
		if (state_q == S_UP && ph_q == 2'd1) begin
			c0_q <= rd_data.min_val;
		end
	end

	assign stat.busy    = (state_q != S_IDLE);
	assign stat.done    = (state_q == S_DONE) && (cmd_q.op == FN_QUERY);
	assign stat.minimum = acc_q;

endmodule

FILE: src/lrmt_checker.sv
module lrmt_checker import lrmt_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic [1:0]        func,
	input logic [LEAF_W-1:0] left_index,
	input logic [LEAF_W-1:0] right_index,
	input logic              result_valid,
	input logic [VAL_W-1:0]  minimum
);

	logic take;
	assign take = start && !busy;

	// only a query produces a result
	a_no_result_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		(take && func != FN_QUERY) |=> !result_valid)
		else $error("result after a non-query item");

	// results come from a walk in progress or straight after a query
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (busy || $past(take && func == FN_QUERY)))
		else $error("result with no query behind it");

	a_busy_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(take))
		else $error("busy rose with no item taken");

	a_empty_query: assert property (@(posedge clk) disable iff (!arst_n)
		(take && func == FN_QUERY && left_index > right_index)
		|=> (result_valid && minimum == EMPTY_MIN))
		else $error("empty range query did not return the empty marker");

endmodule

bind lazy_range_add_range_min_tree lrmt_checker u_lrmt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.func         (func),
	.left_index   (left_index),
	.right_index  (right_index),
	.result_valid (result_valid),
	.minimum      (minimum)
);
